FILE: sv/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types and codes for the word memory with hardware stack.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int BYTE_BITS = 8;
  localparam int WORD_BITS = 16;
  localparam int SP_OUT_BITS = 8;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PUSH  = 2'd2,
    MODE_POP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ADDR  = 2'd1,
    ST_OVER  = 2'd2,
    ST_UNDER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WR0,
    S_WR1,
    S_DONE
  } state_t;

endpackage

FILE: sv/wms_ram.sv
// ----------------------------------------------------------------------------
// wms_ram
// Generic single-port RAM with one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module wms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/word_memory_with_stack.sv
// ----------------------------------------------------------------------------
// word_memory_with_stack
// Byte memory reached as little-endian 16-bit words, with a word stack.
// ----------------------------------------------------------------------------
// Each beat on the input is a word read, word write, push or pop; each gives
// exactly one result beat with the word read, a status code and the stack
// pointer after the operation. The memory is a single-port byte RAM, so a
// word goes through it one byte per cycle: a read or pop steps through S_RD0,
// S_RD1, S_RD2 and S_DONE, a write or push through S_WR0, S_WR1 and S_DONE,
// and a failed operation goes straight to S_DONE. The input stalls while an
// item is in progress; a finished result sits in an output register, so the
// next beat can be taken while the result waits. After reset a clearing pass
// writes zero to every byte, during which no input beat is taken.
// ----------------------------------------------------------------------------
module word_memory_with_stack
  import wms_pkg::*;
#(
  parameter int ADDRESS_BITS = 8,
  parameter int STACK_BYTES  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_mode,
  input  logic [BYTE_BITS-1:0]   in_byte_address,
  input  logic [WORD_BITS-1:0]   in_data_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [WORD_BITS-1:0]   out_read_word,
  output logic [1:0]             out_status,
  output logic [SP_OUT_BITS-1:0] out_stack_pointer
);

  localparam int MEM_SIZE     = 1 << ADDRESS_BITS;
  localparam int STACK_ORIGIN = MEM_SIZE - STACK_BYTES;
  localparam int PUSH_LIMIT   = STACK_ORIGIN - STACK_BYTES + 1;
  localparam logic [ADDRESS_BITS-1:0] SP_RESET = STACK_ORIGIN[ADDRESS_BITS-1:0];
  localparam logic [ADDRESS_BITS-1:0] TOP_ADDR = {ADDRESS_BITS{1'b1}};
  localparam logic [ADDRESS_BITS-1:0] TWO      = ADDRESS_BITS'(2);
  localparam logic [ADDRESS_BITS-1:0] ONE      = ADDRESS_BITS'(1);

  state_t                  state_r, state_nxt;
  logic [ADDRESS_BITS-1:0] sp_r, sp_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [WORD_BITS-1:0]    data_r, data_nxt;
  logic [WORD_BITS-1:0]    word_r, word_nxt;
  logic [BYTE_BITS-1:0]    lo_r, lo_nxt;
  status_t                 status_r, status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0]    out_word_r, out_word_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [ADDRESS_BITS-1:0] out_sp_r, out_sp_nxt;

  logic                    ram_we;
  logic [ADDRESS_BITS-1:0] ram_addr;
  logic [BYTE_BITS-1:0]    ram_wdata;
  logic [BYTE_BITS-1:0]    ram_rdata;

  logic [ADDRESS_BITS+BYTE_BITS-1:0] in_addr_wide;
  logic [ADDRESS_BITS-1:0]           in_addr;
  logic [ADDRESS_BITS-1:0]           push_addr;
  logic [ADDRESS_BITS+BYTE_BITS-1:0] sp_out_wide;
  logic                              accept;
  logic                              out_free;

  // address kept to the memory's width
  assign in_addr_wide = {{ADDRESS_BITS{1'b0}}, in_byte_address};
  assign in_addr      = in_addr_wide[ADDRESS_BITS-1:0];
  assign push_addr    = sp_r - TWO;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  wms_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (MEM_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sp_r        <= SP_RESET;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r       <= data_nxt;
    word_r       <= word_nxt;
    lo_r         <= lo_nxt;
    status_r     <= status_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_sp_r     <= out_sp_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    addr_nxt       = addr_r;
    data_nxt       = data_r;
    word_nxt       = word_r;
    lo_nxt         = lo_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_sp_nxt     = out_sp_r;
    ram_we         = 1'b0;
    ram_addr       = addr_r;
    ram_wdata      = data_r[BYTE_BITS-1:0];
    in_stall       = (state_r != S_IDLE);

    unique case (state_r)
      S_CLEAR: begin
        // zero one byte per cycle, addr_r sweeps the whole memory
        ram_we    = 1'b1;
        ram_wdata = '0;
        addr_nxt  = addr_r + ONE;
        if (addr_r == TOP_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          data_nxt   = in_data_word;
          word_nxt   = '0;
          status_nxt = ST_OK;
          unique case (mode_t'(in_mode))
            MODE_READ: begin
              addr_nxt = in_addr;
              if (in_addr == TOP_ADDR) begin
                status_nxt = ST_ADDR;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_RD0;
              end
            end
            MODE_WRITE: begin
              addr_nxt = in_addr;
              if (in_addr == TOP_ADDR) begin
                status_nxt = ST_ADDR;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_WR0;
              end
            end
            MODE_PUSH: begin
              addr_nxt = push_addr;
              if (int'(sp_r) <= PUSH_LIMIT) begin
                status_nxt = ST_OVER;
                state_nxt  = S_DONE;
              end else if (sp_r < TWO || push_addr == TOP_ADDR) begin
                status_nxt = ST_ADDR;
                state_nxt  = S_DONE;
              end else begin
                sp_nxt    = push_addr;
                state_nxt = S_WR0;
              end
            end
            MODE_POP: begin
              addr_nxt = sp_r;
              if (int'(sp_r) >= STACK_ORIGIN) begin
                status_nxt = ST_UNDER;
                state_nxt  = S_DONE;
              end else if (sp_r == TOP_ADDR) begin
                status_nxt = ST_ADDR;
                state_nxt  = S_DONE;
              end else begin
                sp_nxt    = sp_r + TWO;
                state_nxt = S_RD0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RD0: begin
        addr_nxt  = addr_r + ONE;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        // low byte arrives while the high byte is addressed
        lo_nxt    = ram_rdata;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        word_nxt  = {ram_rdata, lo_r};
        state_nxt = S_DONE;
      end
      S_WR0: begin
        ram_we    = 1'b1;
        addr_nxt  = addr_r + ONE;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        ram_we    = 1'b1;
        ram_wdata = data_r[WORD_BITS-1:BYTE_BITS];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = word_r;
          out_status_nxt = status_r;
          out_sp_nxt     = sp_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign sp_out_wide       = {{BYTE_BITS{1'b0}}, out_sp_r};
  assign out_valid         = out_valid_r;
  assign out_read_word     = out_word_r;
  assign out_status        = out_status_r;
  assign out_stack_pointer = sp_out_wide[SP_OUT_BITS-1:0];

endmodule

FILE: bench/word_memory_with_stack_test.sv
// ----------------------------------------------------------------------------
// word_memory_with_stack_test
// Self-checking bench for the byte memory with word stack.
// ----------------------------------------------------------------------------
// A directed table covers reset contents, the word at the top address, a full
// stack and an empty stack. Random reads, writes and push/pop runs follow.
// Each accepted beat is run through a local model of the memory and stack
// pointer, and every result beat is compared with the oldest prediction.
// Both sides idle at random in the first two phases, not in the third. The
// receiver also holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module word_memory_with_stack_test;
  import wms_pkg::*;

  localparam int MEM_BYTES = 256;
  localparam int LAST_BYTE = MEM_BYTES - 1;
  localparam int STACK_DEPTH = 16;
  localparam int STACK_BASE = MEM_BYTES - STACK_DEPTH;
  localparam int STACK_FLOOR = STACK_BASE - STACK_DEPTH + 1;
  localparam logic [7:0] SP_EMPTY = 8'd240;
  localparam logic [7:0] SP_FULL = 8'd224;
  localparam int ITEMS_PER_PHASE = 550;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [15:0] rd;
    status_t     st;
    logic [7:0]  sp;
  } result_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  addr;
    logic [15:0] data;
    logic        fixed;
    result_t     res;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_READ;
  logic [7:0]  in_byte_address = 8'h00;
  logic [15:0] in_data_word = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_read_word;
  logic [1:0]  out_status;
  logic [7:0]  out_stack_pointer;

  // model state
  logic [7:0] mem_image [MEM_BYTES] = '{default: 8'h00};
  int         sp_image = STACK_BASE;
  result_t    expected_q [$];

  int send_idle = 29;
  int recv_idle = 85;
  int phase = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;

  // directed table: typed results only where obvious, zero-filled rows use the model
  step_t directed [27] = '{
    '{MODE_READ,  8'd0,   16'h0000, 1'b1, '{16'h0000, ST_OK,    SP_EMPTY}},
    '{MODE_READ,  8'd255, 16'h0000, 1'b1, '{16'h0000, ST_ADDR,  SP_EMPTY}},
    '{MODE_WRITE, 8'd255, 16'hffff, 1'b1, '{16'h0000, ST_ADDR,  SP_EMPTY}},
    '{MODE_WRITE, 8'd254, 16'hffff, 1'b1, '{16'h0000, ST_OK,    SP_EMPTY}},
    '{MODE_READ,  8'd254, 16'h0000, 1'b1, '{16'hffff, ST_OK,    SP_EMPTY}},
    '{MODE_READ,  8'd253, 16'h0000, 1'b1, '{16'hff00, ST_OK,    SP_EMPTY}},
    '{MODE_POP,   8'd0,   16'h0000, 1'b1, '{16'h0000, ST_UNDER, SP_EMPTY}},
    '{MODE_WRITE, 8'd0,   16'h8001, 1'b1, '{16'h0000, ST_OK,    SP_EMPTY}},
    '{MODE_READ,  8'd0,   16'h0000, 1'b0, '0},
    '{MODE_PUSH,  8'd255, 16'h0001, 1'b0, '0},
    '{MODE_PUSH,  8'd0,   16'h8000, 1'b0, '0},
    '{MODE_PUSH,  8'd17,  16'h1234, 1'b0, '0},
    '{MODE_PUSH,  8'd238, 16'ha5c3, 1'b0, '0},
    '{MODE_PUSH,  8'd128, 16'h5a3c, 1'b0, '0},
    '{MODE_PUSH,  8'd64,  16'h0000, 1'b0, '0},
    '{MODE_PUSH,  8'd224, 16'hffff, 1'b0, '0},
    '{MODE_PUSH,  8'd1,   16'h7ffe, 1'b0, '0},
    '{MODE_PUSH,  8'd0,   16'hbeef, 1'b1, '{16'h0000, ST_OVER,  SP_FULL}},
    '{MODE_POP,   8'd0,   16'hffff, 1'b0, '0},
    '{MODE_POP,   8'd255, 16'h0000, 1'b0, '0},
    '{MODE_POP,   8'd0,   16'h0000, 1'b0, '0},
    '{MODE_POP,   8'd0,   16'h0000, 1'b0, '0},
    '{MODE_POP,   8'd0,   16'h0000, 1'b0, '0},
    '{MODE_POP,   8'd0,   16'h0000, 1'b0, '0},
    '{MODE_POP,   8'd0,   16'h0000, 1'b0, '0},
    '{MODE_POP,   8'd0,   16'h0000, 1'b0, '0},
    '{MODE_POP,   8'd0,   16'h0000, 1'b1, '{16'h0000, ST_UNDER, SP_EMPTY}}
  };

  word_memory_with_stack u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_byte_address   (in_byte_address),
    .in_data_word      (in_data_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_word     (out_read_word),
    .out_status        (out_status),
    .out_stack_pointer (out_stack_pointer)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one access to the local memory image and returns its result
  function automatic result_t model_access(mode_t m, logic [7:0] a, logic [15:0] d);
    result_t r;
    int ai;
    r = '{16'h0000, ST_OK, 8'h00};
    ai = a;
    case (m)
      MODE_READ: begin
        if (ai < LAST_BYTE) r.rd = {mem_image[ai + 1], mem_image[ai]};
        else r.st = ST_ADDR;
      end
      MODE_WRITE: begin
        if (ai < LAST_BYTE) begin
          mem_image[ai] = d[7:0];
          mem_image[ai + 1] = d[15:8];
        end else begin
          r.st = ST_ADDR;
        end
      end
      MODE_PUSH: begin
        if (sp_image <= STACK_FLOOR) begin
          r.st = ST_OVER;
        end else if (sp_image - 2 < 0 || sp_image - 2 >= LAST_BYTE) begin
          r.st = ST_ADDR;
        end else begin
          sp_image = sp_image - 2;
          mem_image[sp_image] = d[7:0];
          mem_image[sp_image + 1] = d[15:8];
        end
      end
      default: begin
        if (sp_image >= STACK_BASE) begin
          r.st = ST_UNDER;
        end else if (sp_image < 0 || sp_image >= LAST_BYTE) begin
          r.st = ST_ADDR;
        end else begin
          r.rd = {mem_image[sp_image + 1], mem_image[sp_image]};
          sp_image = sp_image + 2;
        end
      end
    endcase
    r.sp = sp_image[7:0];
    return r;
  endfunction

  // biased toward both ends of memory and the stack region
  function automatic logic [7:0] pick_address();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd253;
          3: return 8'd254;
          default: return 8'd255;
        endcase
      end
      1: return 8'($urandom_range(220, 243));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(mode_t m, logic [7:0] a, logic [15:0] d, logic fixed,
                           result_t typed);
    result_t pred;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_byte_address <= a;
    in_data_word <= d;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = model_access(m, a, d);
    expected_q.push_back(fixed ? typed : pred);
  endtask

  task automatic report(string field, int want, int got);
    fail_count++;
    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat, expected none got rd=%0h st=%0d sp=%0d",
                 $time, out_read_word, out_status, out_stack_pointer);
      end else begin
        want = expected_q.pop_front();
        if (out_read_word !== want.rd) report("read_word", want.rd, out_read_word);
        if (out_status !== want.st) report("status", want.st, out_status);
        if (out_stack_pointer !== want.sp)
          report("stack_pointer", want.sp, out_stack_pointer);
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (phase == 2 && !hold_done) begin
      // long hold-off so the block fills and stalls its input
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    mode_t m;
    int n;
    int run_len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_item(directed[i].mode, directed[i].addr, directed[i].data,
                directed[i].fixed, directed[i].res);

    for (int p = 0; p < 3; p++) begin
      phase = p;
      case (p)
        0: begin send_idle = 29; recv_idle = 85; end
        1: begin send_idle = 85; recv_idle = 29; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 12) begin
          // run of pushes or pops to reach both stack limits
          run_len = $urandom_range(1, 11);
          m = $urandom_range(0, 1) ? MODE_PUSH : MODE_POP;
          repeat (run_len) begin
            send_item(m, 8'($urandom), pick_data(), 1'b0, '0);
            n++;
          end
        end else begin
          m = mode_t'($urandom_range(0, 3));
          send_item(m, pick_address(), pick_data(), 1'b0, '0);
          n++;
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
sv/wms_pkg.sv
sv/wms_ram.sv
sv/word_memory_with_stack.sv
bench/word_memory_with_stack_test.sv
